// ----- hw/rtl/ctb_pkg.sv -----
// ----------------------------------------------------------------------------
// ctb_pkg
// Types, codes and constants shared by the cascaded timer bank modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ctb_pkg;

  localparam int unsigned NUM_TMR  = 8;
  localparam int unsigned TMR_W    = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PHASE_W  = 6;
  localparam int unsigned IN_US_W  = 10;

  // control A bit positions
  localparam int unsigned CTLA_INT_BIT    = 7;
  localparam int unsigned CTLA_RELOAD_BIT = 4;
  localparam int unsigned CTLA_COUNT_BIT  = 3;
  localparam logic [2:0]  LINKED_SEL      = 3'd7;
  localparam logic [BYTE_W-1:0] CTLB_SET_MASK = 8'h09;  // done | borrow-out
  localparam logic [TMR_W-1:0]  LAST_TMR      = 3'd7;

  typedef enum logic [2:0] {
    OP_ADVANCE = 3'd0,
    OP_WRITE   = 3'd1,
    OP_READ    = 3'd2,
    OP_ACK     = 3'd3,
    OP_RAISE   = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    REG_BACKUP = 2'd0,
    REG_CTLA   = 2'd1,
    REG_COUNT  = 2'd2,
    REG_CTLB   = 2'd3
  } reg_sel_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_TICK = 5'b00100,
    ST_EXEC = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [TMR_W-1:0]   timer_index;
    logic [1:0]         reg_select;
    logic [BYTE_W-1:0]  write_data;
    logic [IN_US_W-1:0] elapsed_us;
    logic [BYTE_W-1:0]  irq_mask;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic [BYTE_W-1:0] irq_latch_value;
    logic              irq_pending;
  } out_item_t;

  // register file write request for the addressed timer
  typedef struct packed {
    logic               backup_we;
    logic               ctla_we;
    logic               count_we;
    logic               ctlb_we;
    logic               phase_we;
    logic [BYTE_W-1:0]  backup;
    logic [BYTE_W-1:0]  ctla;
    logic [BYTE_W-1:0]  count;
    logic [BYTE_W-1:0]  ctlb;
    logic [PHASE_W-1:0] phase;
  } rf_wr_t;

  // register file read data for the addressed timer
  typedef struct packed {
    logic [BYTE_W-1:0]  backup;
    logic [BYTE_W-1:0]  ctla;
    logic [BYTE_W-1:0]  count;
    logic [BYTE_W-1:0]  ctlb;
    logic [PHASE_W-1:0] phase;
  } rf_rd_t;

  typedef struct packed {
    logic             vld;
    logic [TMR_W-1:0] idx;
  } succ_t;

  // linked chain 0->2->4->1->3->5->7; timers 6 and 7 end it
  function automatic succ_t next_in_chain(input logic [TMR_W-1:0] t);
    succ_t s;
    s.vld = 1'b1;
    case (t)
      3'd0:    s.idx = 3'd2;
      3'd1:    s.idx = 3'd3;
      3'd2:    s.idx = 3'd4;
      3'd3:    s.idx = 3'd5;
      3'd4:    s.idx = 3'd1;
      3'd5:    s.idx = 3'd7;
      default: begin
        s.vld = 1'b0;
        s.idx = 3'd0;
      end
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ctb_regfile.sv -----
// ----------------------------------------------------------------------------
// ctb_regfile
// Per-timer byte registers and phase accumulators, one timer addressed a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_regfile (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [ctb_pkg::TMR_W-1:0]       addr_i,
  input  wire ctb_pkg::rf_wr_t                 wr_i,
  output ctb_pkg::rf_rd_t                      rd_o,
  output logic      [ctb_pkg::NUM_TMR-1:0]     linked_o
);

  logic [ctb_pkg::BYTE_W-1:0]  backup_q [ctb_pkg::NUM_TMR];
  logic [ctb_pkg::BYTE_W-1:0]  ctla_q   [ctb_pkg::NUM_TMR];
  logic [ctb_pkg::BYTE_W-1:0]  count_q  [ctb_pkg::NUM_TMR];
  logic [ctb_pkg::BYTE_W-1:0]  ctlb_q   [ctb_pkg::NUM_TMR];
  logic [ctb_pkg::PHASE_W-1:0] phase_q  [ctb_pkg::NUM_TMR];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ctb_pkg::NUM_TMR; i++) begin
        backup_q[i] <= '0;
        ctla_q[i]   <= '0;
        count_q[i]  <= '0;
        ctlb_q[i]   <= '0;
        phase_q[i]  <= '0;
      end
    end else begin
      if (wr_i.backup_we) backup_q[addr_i] <= wr_i.backup;
      if (wr_i.ctla_we)   ctla_q[addr_i]   <= wr_i.ctla;
      if (wr_i.count_we)  count_q[addr_i]  <= wr_i.count;
      if (wr_i.ctlb_we)   ctlb_q[addr_i]   <= wr_i.ctlb;
      if (wr_i.phase_we)  phase_q[addr_i]  <= wr_i.phase;
    end
  end

  always_comb begin
    rd_o.backup = backup_q[addr_i];
    rd_o.ctla   = ctla_q[addr_i];
    rd_o.count  = count_q[addr_i];
    rd_o.ctlb   = ctlb_q[addr_i];
    rd_o.phase  = phase_q[addr_i];
  end

  // per-timer "enabled and linked" flags for the cascade check
  always_comb begin
    for (int i = 0; i < ctb_pkg::NUM_TMR; i++) begin
      linked_o[i] = ctla_q[i][ctb_pkg::CTLA_COUNT_BIT] &&
                    (ctla_q[i][2:0] == ctb_pkg::LINKED_SEL);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ctb_seq.sv -----
// ----------------------------------------------------------------------------
// ctb_seq
// Sequencer: scans timers, services ticks and cascades one per cycle, runs
// bus transactions and holds the interrupt latch.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_seq #(
  parameter int unsigned ELAPSED_BITS = 10
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire ctb_pkg::in_item_t           in_data_i,
  output logic                             res_valid_o,
  input  wire logic                        res_ready_i,
  output ctb_pkg::out_item_t               res_o,
  output logic      [ctb_pkg::TMR_W-1:0]   rf_addr_o,
  output ctb_pkg::rf_wr_t                  rf_wr_o,
  input  wire ctb_pkg::rf_rd_t             rf_rd_i,
  input  wire logic [ctb_pkg::NUM_TMR-1:0] linked_i
);

  localparam int unsigned US_W = (ELAPSED_BITS < ctb_pkg::IN_US_W) ?
                                 ELAPSED_BITS : ctb_pkg::IN_US_W;
  localparam int unsigned PH_W = ((US_W > ctb_pkg::PHASE_W) ?
                                  US_W : ctb_pkg::PHASE_W) + 1;

  ctb_pkg::state_e            state_q, state_d;
  ctb_pkg::in_item_t          item_q, item_d;
  logic [ctb_pkg::TMR_W-1:0]  scan_q, scan_d;
  logic [ctb_pkg::TMR_W-1:0]  tgt_q, tgt_d;
  logic [PH_W-1:0]            rem_q, rem_d;
  logic [ctb_pkg::BYTE_W-1:0] latch_q, latch_d;
  logic [ctb_pkg::BYTE_W-1:0] rd_q, rd_d;

  logic                       in_acc;
  logic [2:0]                 sel;
  logic [PH_W-1:0]            sum;
  logic [PH_W-1:0]            ticks;
  logic [ctb_pkg::PHASE_W:0]  ph_mask;
  ctb_pkg::succ_t             succ;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ctb_pkg::ST_IDLE);

  // shared adder and shifter for the phase update
  assign sel     = rf_rd_i.ctla[2:0];
  assign sum     = PH_W'(rf_rd_i.phase) + PH_W'(item_q.elapsed_us[US_W-1:0]);
  assign ticks   = sum >> sel;
  assign ph_mask = ((ctb_pkg::PHASE_W+1)'(1) << sel) - (ctb_pkg::PHASE_W+1)'(1);
  assign succ    = ctb_pkg::next_in_chain(tgt_q);

  always_comb begin
    case (state_q)
      ctb_pkg::ST_SCAN: rf_addr_o = scan_q;
      ctb_pkg::ST_TICK: rf_addr_o = tgt_q;
      default:          rf_addr_o = item_q.timer_index;
    endcase
  end

  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    scan_d  = scan_q;
    tgt_d   = tgt_q;
    rem_d   = rem_q;
    latch_d = latch_q;
    rd_d    = rd_q;
    rf_wr_o = '0;
    rf_wr_o.backup = item_q.write_data;
    rf_wr_o.ctla   = item_q.write_data;
    rf_wr_o.count  = item_q.write_data;
    rf_wr_o.ctlb   = item_q.write_data;
    rf_wr_o.phase  = sum[ctb_pkg::PHASE_W-1:0] & ph_mask[ctb_pkg::PHASE_W-1:0];
    res_valid_o = 1'b0;

    case (state_q)
      ctb_pkg::ST_IDLE: begin
        if (in_acc) begin
          item_d = in_data_i;
          rd_d   = '0;
          scan_d = '0;
          if (in_data_i.opcode == ctb_pkg::OP_ADVANCE) begin
            state_d = ctb_pkg::ST_SCAN;
          end else begin
            state_d = ctb_pkg::ST_EXEC;
          end
        end
      end

      ctb_pkg::ST_SCAN: begin
        if (rf_rd_i.ctla[ctb_pkg::CTLA_COUNT_BIT] && (sel != ctb_pkg::LINKED_SEL)) begin
          rf_wr_o.phase_we = 1'b1;
        end
        if (rf_rd_i.ctla[ctb_pkg::CTLA_COUNT_BIT] && (sel != ctb_pkg::LINKED_SEL) &&
            (ticks != '0)) begin
          rem_d   = ticks;
          tgt_d   = scan_q;
          state_d = ctb_pkg::ST_TICK;
        end else if (scan_q == ctb_pkg::LAST_TMR) begin
          state_d = ctb_pkg::ST_FIN;
        end else begin
          scan_d = scan_q + ctb_pkg::TMR_W'(1);
        end
      end

      ctb_pkg::ST_TICK: begin
        if (rf_rd_i.count != '0) begin
          rf_wr_o.count_we = 1'b1;
          rf_wr_o.count    = rf_rd_i.count - ctb_pkg::BYTE_W'(1);
        end else begin
          // underflow
          rf_wr_o.count_we = rf_rd_i.ctla[ctb_pkg::CTLA_RELOAD_BIT];
          rf_wr_o.count    = rf_rd_i.backup;
          rf_wr_o.ctlb_we  = 1'b1;
          rf_wr_o.ctlb     = rf_rd_i.ctlb | ctb_pkg::CTLB_SET_MASK;
          if (rf_rd_i.ctla[ctb_pkg::CTLA_INT_BIT]) begin
            latch_d = latch_q | (ctb_pkg::BYTE_W'(1) << tgt_q);
          end
        end
        if ((rf_rd_i.count == '0) && succ.vld && linked_i[succ.idx]) begin
          tgt_d = succ.idx;
        end else begin
          // chain finished: one tick of the scanned timer is done
          tgt_d = scan_q;
          rem_d = rem_q - PH_W'(1);
          if (rem_q == PH_W'(1)) begin
            if (scan_q == ctb_pkg::LAST_TMR) begin
              state_d = ctb_pkg::ST_FIN;
            end else begin
              scan_d  = scan_q + ctb_pkg::TMR_W'(1);
              state_d = ctb_pkg::ST_SCAN;
            end
          end
        end
      end

      ctb_pkg::ST_EXEC: begin
        state_d = ctb_pkg::ST_FIN;
        case (item_q.opcode)
          ctb_pkg::OP_WRITE: begin
            case (item_q.reg_select)
              ctb_pkg::REG_BACKUP: rf_wr_o.backup_we = 1'b1;
              ctb_pkg::REG_CTLA:   rf_wr_o.ctla_we   = 1'b1;
              ctb_pkg::REG_COUNT:  rf_wr_o.count_we  = 1'b1;
              default:             rf_wr_o.ctlb_we   = 1'b1;
            endcase
          end
          ctb_pkg::OP_READ: begin
            case (item_q.reg_select)
              ctb_pkg::REG_BACKUP: rd_d = rf_rd_i.backup;
              ctb_pkg::REG_CTLA:   rd_d = rf_rd_i.ctla;
              ctb_pkg::REG_COUNT:  rd_d = rf_rd_i.count;
              default:             rd_d = rf_rd_i.ctlb;
            endcase
          end
          ctb_pkg::OP_ACK:   latch_d = latch_q & ~item_q.irq_mask;
          ctb_pkg::OP_RAISE: latch_d = latch_q | item_q.irq_mask;
          default: ;
        endcase
      end

      ctb_pkg::ST_FIN: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ctb_pkg::ST_IDLE;
        end
      end

      default: state_d = ctb_pkg::ST_IDLE;
    endcase
  end

  assign res_o.read_data       = rd_q;
  assign res_o.irq_latch_value = latch_q;
  assign res_o.irq_pending     = (latch_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ctb_pkg::ST_IDLE;
      scan_q  <= '0;
      tgt_q   <= '0;
      rem_q   <= '0;
      latch_q <= '0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      tgt_q   <= tgt_d;
      rem_q   <= rem_d;
      latch_q <= latch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    rd_q   <= rd_d;
  end

`ifndef SYNTHESIS
  a_tick_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ctb_pkg::ST_TICK) |-> (rem_q != '0))
    else $error("tick state with no ticks left");

  a_bus_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.opcode != ctb_pkg::OP_ADVANCE)) |=>
      (state_q == ctb_pkg::ST_EXEC))
    else $error("bus transaction did not enter exec");

  a_latch_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != ctb_pkg::ST_TICK) && (state_q != ctb_pkg::ST_EXEC)) |=>
      $stable(latch_q))
    else $error("interrupt latch changed outside tick or exec");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ctb_pkg::ST_FIN) |-> ((scan_q == ctb_pkg::LAST_TMR) ||
      (item_q.opcode != ctb_pkg::OP_ADVANCE)))
    else $error("advance finished before the last timer");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/cascaded_timer_bank_with_irq_latch.sv -----
// ----------------------------------------------------------------------------
// cascaded_timer_bank_with_irq_latch
// Eight cascadable 8-bit down-counting timers with an interrupt latch.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------
//  in      | input     | in_valid_i/in_stall_o   | ctb_pkg::in_item_t
//  out     | output    | out_valid_o/out_stall_i | ctb_pkg::out_item_t
//
//  Bus transactions pass through the exec and finish states and load the
//  output register as they leave finish. Advance scans the timers in
//  turn and serves each tick and cascaded tick in the tick state before
//  finish; a full, stalled output register adds its wait.
//  Input is stalled while a transaction is in work; one result may wait in
//  the output register while the next transaction is taken.
//  Reset is asynchronous and clears all timer bytes, phases and the latch.
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_timer_bank_with_irq_latch #(
  parameter int unsigned ELAPSED_BITS = 10
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire ctb_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output ctb_pkg::out_item_t      out_data_o
);

  logic [ctb_pkg::TMR_W-1:0]   rf_addr;
  ctb_pkg::rf_wr_t             rf_wr;
  ctb_pkg::rf_rd_t             rf_rd;
  logic [ctb_pkg::NUM_TMR-1:0] linked;
  logic                        res_valid;
  logic                        res_ready;
  ctb_pkg::out_item_t          res;
  logic                        out_valid_q;
  ctb_pkg::out_item_t          out_q;

  ctb_regfile u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .addr_i   (rf_addr),
    .wr_i     (rf_wr),
    .rd_o     (rf_rd),
    .linked_o (linked)
  );

  ctb_seq #(
    .ELAPSED_BITS (ELAPSED_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .rf_addr_o   (rf_addr),
    .rf_wr_o     (rf_wr),
    .rf_rd_i     (rf_rd),
    .linked_i    (linked)
  );

  // output register
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
